### rtl/source_tokenizer_defines.svh
// assertion macros shared by the tokenizer modules
`ifndef SOURCE_TOKENIZER_DEFINES_SVH
`define SOURCE_TOKENIZER_DEFINES_SVH

// a property that must hold on every clock edge out of reset
`define ST_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// an implication whose consequent is checked in the cycle after the antecedent
`define ST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/stok_pkg.sv
`timescale 1ns / 1ps
package stok_pkg;
	localparam int POS_BITS = 32;
	localparam int LEN_BITS = 16;
	localparam int KEYWORD_CHARS = 6;
	localparam int KW_BITS = KEYWORD_CHARS * 8;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	localparam logic [6:0] K_END = 7'd0;
	localparam logic [6:0] K_IDENT = 7'd1;
	localparam logic [6:0] K_INT = 7'd2;
	localparam logic [6:0] K_FLOAT = 7'd3;
	localparam logic [6:0] K_STRING = 7'd4;
	localparam logic [6:0] K_ERROR = 7'd5;
	localparam logic [6:0] K_KW0 = 7'd6;
	localparam logic [6:0] K_BOOLLIT = 7'd29;
	localparam logic [6:0] K_OP0 = 7'd30;
	localparam logic [6:0] K_DOT = 7'd71;

	typedef enum logic [11:0] {
		M_IDLE = 12'b0000_0000_0001, M_OP1 = 12'b0000_0000_0010,
		M_OP2 = 12'b0000_0000_0100, M_IDENT = 12'b0000_0000_1000,
		M_INT = 12'b0000_0001_0000, M_INT_DOT = 12'b0000_0010_0000,
		M_FLOAT = 12'b0000_0100_0000, M_STRING = 12'b0000_1000_0000,
		M_STR_ESC = 12'b0001_0000_0000, M_LINE = 12'b0010_0000_0000,
		M_BLOCK = 12'b0100_0000_0000, M_BLOCK_STAR = 12'b1000_0000_0000
	} mode_t;

	typedef struct packed {
		logic [6:0] kind;
		logic [POS_BITS-1:0] start;
		logic [LEN_BITS-1:0] len;
		logic last;
	} tok_t;

	// room for four tokens caused by one byte, packed in order; a byte causes at most three
	typedef struct packed {
		logic [2:0] cnt;
		tok_t [3:0] tok;
	} bundle_t;

	function automatic logic [6:0] op1(input logic [7:0] c);
		logic [6:0] k;
		k = K_ERROR;
		case (c)
			"+": k = K_OP0 + 7'd20;
			"-": k = K_OP0 + 7'd21;
			"*": k = K_OP0 + 7'd22;
			"/": k = K_OP0 + 7'd23;
			"%": k = K_OP0 + 7'd24;
			"=": k = K_OP0 + 7'd25;
			"<": k = K_OP0 + 7'd26;
			">": k = K_OP0 + 7'd27;
			"&": k = K_OP0 + 7'd28;
			"|": k = K_OP0 + 7'd29;
			"^": k = K_OP0 + 7'd30;
			"~": k = K_OP0 + 7'd31;
			"!": k = K_OP0 + 7'd32;
			"?": k = K_OP0 + 7'd33;
			":": k = K_OP0 + 7'd34;
			"(": k = K_OP0 + 7'd35;
			")": k = K_OP0 + 7'd36;
			"{": k = K_OP0 + 7'd37;
			"}": k = K_OP0 + 7'd38;
			",": k = K_OP0 + 7'd39;
			";": k = K_OP0 + 7'd40;
			".": k = K_DOT;
			default: k = K_ERROR;
		endcase
		return k;
	endfunction

	// two-byte operator, error kind if none
	function automatic logic [6:0] op2(input logic [7:0] a, input logic [7:0] b);
		logic [6:0] k;
		k = K_ERROR;
		if (b == "=") begin
			case (a)
				"+": k = K_OP0 + 7'd4;
				"-": k = K_OP0 + 7'd5;
				"*": k = K_OP0 + 7'd6;
				"/": k = K_OP0 + 7'd7;
				"%": k = K_OP0 + 7'd8;
				"&": k = K_OP0 + 7'd9;
				"|": k = K_OP0 + 7'd10;
				"^": k = K_OP0 + 7'd11;
				"=": k = K_OP0 + 7'd12;
				"!": k = K_OP0 + 7'd13;
				"<": k = K_OP0 + 7'd14;
				">": k = K_OP0 + 7'd15;
				default: k = K_ERROR;
			endcase
		end else if (a == b) begin
			case (a)
				"+": k = K_OP0 + 7'd2;
				"-": k = K_OP0 + 7'd3;
				"<": k = K_OP0 + 7'd16;
				">": k = K_OP0 + 7'd17;
				"&": k = K_OP0 + 7'd18;
				"|": k = K_OP0 + 7'd19;
				default: k = K_ERROR;
			endcase
		end
		return k;
	endfunction

	function automatic logic starts_long(input logic [7:0] c);
		return c == "<" || c == ">" || c == "+" || c == "-" || c == "*" || c == "/" ||
			c == "%" || c == "&" || c == "|" || c == "^" || c == "=" || c == "!";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic [KW_BITS-1:0] pk(input logic [63:0] s);
		return s[KW_BITS-1:0];
	endfunction

	// keyword lookup on the packed prefix, first byte in the low byte
	function automatic logic [6:0] kw_kind(input logic [KW_BITS-1:0] p,
			input logic [LEN_BITS-1:0] n);
		logic [6:0] k;
		k = K_IDENT;
		if (n <= LEN_BITS'(KEYWORD_CHARS)) begin
			case (p)
				pk(64'h636e7566): if (n == 4) k = K_KW0;
				pk(64'h6e7265747865): if (n == 6) k = K_KW0 + 7'd1;
				pk(64'h6e7275746572): if (n == 6) k = K_KW0 + 7'd2;
				pk(64'h656c696877): if (n == 5) k = K_KW0 + 7'd3;
				pk(64'h726f66): if (n == 3) k = K_KW0 + 7'd4;
				pk(64'h6669): if (n == 2) k = K_KW0 + 7'd5;
				pk(64'h65736c65): if (n == 4) k = K_KW0 + 7'd6;
				pk(64'h657375): if (n == 3) k = K_KW0 + 7'd7;
				pk(64'h74756d): if (n == 3) k = K_KW0 + 7'd8;
				pk(64'h726176): if (n == 3) k = K_KW0 + 7'd9;
				pk(64'h63696c627570): if (n == 6) k = K_KW0 + 7'd10;
				pk(64'h64696f76): if (n == 4) k = K_KW0 + 7'd11;
				pk(64'h6c6f6f62): if (n == 4) k = K_KW0 + 7'd12;
				pk(64'h38746e69): if (n == 4) k = K_KW0 + 7'd13;
				pk(64'h3631746e69): if (n == 5) k = K_KW0 + 7'd14;
				pk(64'h3233746e69): if (n == 5) k = K_KW0 + 7'd15;
				pk(64'h3436746e69): if (n == 5) k = K_KW0 + 7'd16;
				pk(64'h38746e6975): if (n == 5) k = K_KW0 + 7'd17;
				pk(64'h3631746e6975): if (n == 6) k = K_KW0 + 7'd18;
				pk(64'h3233746e6975): if (n == 6) k = K_KW0 + 7'd19;
				pk(64'h3436746e6975): if (n == 6) k = K_KW0 + 7'd20;
				pk(64'h32337066): if (n == 4) k = K_KW0 + 7'd21;
				pk(64'h34367066): if (n == 4) k = K_KW0 + 7'd22;
				pk(64'h65757274): if (n == 4) k = K_BOOLLIT;
				pk(64'h65736c6166): if (n == 5) k = K_BOOLLIT;
				default: k = K_IDENT;
			endcase
		end
		return k;
	endfunction
endpackage

### rtl/stok_if.sv
`timescale 1ns / 1ps
interface stok_in_if;
	logic valid;
	logic ready;
	logic [7:0] ch;
	logic end_of_input;
	modport source (output valid, ch, end_of_input, input ready);
	modport sink (input valid, ch, end_of_input, output ready);
endinterface

interface stok_out_if;
	logic valid;
	logic ready;
	logic [6:0] token_kind;
	logic [31:0] start_offset;
	logic [15:0] token_length;
	logic last_of_run;
	modport source (output valid, token_kind, start_offset, token_length, last_of_run,
		input ready);
	modport sink (input valid, token_kind, start_offset, token_length, last_of_run,
		output ready);
endinterface

### rtl/source_tokenizer.sv
`timescale 1ns / 1ps
// source_tokenizer: streaming lexer, one source byte per request on the in channel
// (ch, end_of_input), tokens out on the out channel as kind, start offset, length
// and a last_of_run mark on the final token that a request produced.
// the front scanner takes one request per cycle and writes all tokens that the
// byte closes (up to three) as one bundle into a four-deep queue; the back end
// sends them one per cycle while out.ready is high. a token leaves at the earliest
// in the cycle after the byte that closes it is taken. throughput is one byte per
// cycle while the queue has room; the tokens of one byte leave one after another.
// end_of_input flushes any pending token, sends the end token and returns the
// scanner to offset 0. reset clears scanner state and empties the queue.
// when the receiver stalls, the queue fills and in.ready drops once it is full;
// bytes that close no token (whitespace, comments, token bodies) never wait
// for queue space beyond that.
module source_tokenizer (
	input logic clk,
	input logic arst_n,
	stok_in_if.sink in,
	stok_out_if.source out
);
	logic push, full, pop, empty;
	stok_pkg::bundle_t wb, rb;
	stok_pkg::tok_t tok;

	stok_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in.valid), .in_ready(in.ready),
		.ch(in.ch), .end_of_input(in.end_of_input), .push(push), .bundle(wb),
		.q_full(full)
	);

	stok_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(wb), .full(full),
		.pop(pop), .empty(empty), .rdata(rb)
	);

	stok_back u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .rdata(rb), .pop(pop),
		.out_valid(out.valid), .out_ready(out.ready), .tok(tok)
	);

	assign out.token_kind = tok.kind;
	assign out.start_offset = tok.start;
	assign out.token_length = tok.len;
	assign out.last_of_run = tok.last;
endmodule

### rtl/stok_front.sv
`timescale 1ns / 1ps
`include "source_tokenizer_defines.svh"
module stok_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] ch,
	input logic end_of_input,
	output logic push,
	output stok_pkg::bundle_t bundle,
	input logic q_full
);
	stok_pkg::mode_t mode_q, mode_d;
	logic [7:0] first_q, first_d;
	logic [stok_pkg::KW_BITS-1:0] kw_q, kw_d;
	logic [stok_pkg::POS_BITS-1:0] start_q, start_d, pos_q;
	logic [stok_pkg::LEN_BITS-1:0] len_q, len_d;
	logic fire;
	stok_pkg::bundle_t b;

	assign in_ready = !q_full;
	assign fire = in_valid && in_ready;

	function automatic logic [stok_pkg::LEN_BITS-1:0] grow(
			input logic [stok_pkg::LEN_BITS-1:0] n);
		return (&n) ? n : n + 1'b1;
	endfunction

	always_comb begin
		logic [6:0] k;
		logic idle_scan;
		b = '0;
		mode_d = mode_q;
		first_d = first_q;
		kw_d = kw_q;
		start_d = start_q;
		len_d = len_q;
		idle_scan = 1'b0;
		k = '0;
		if (end_of_input) begin
			unique case (mode_q) inside
				stok_pkg::M_OP1: begin
					k = stok_pkg::op1(first_q);
					b.tok[0] = '{k, start_q, stok_pkg::LEN_BITS'(1), 1'b0};
					b.cnt = 3'd1;
				end
				stok_pkg::M_OP2: begin
					b.tok[0] = '{stok_pkg::op2(first_q, first_q), start_q,
						stok_pkg::LEN_BITS'(2), 1'b0};
					b.cnt = 3'd1;
				end
				stok_pkg::M_IDENT: begin
					b.tok[0] = '{stok_pkg::kw_kind(kw_q, len_q), start_q, len_q, 1'b0};
					b.cnt = 3'd1;
				end
				stok_pkg::M_INT: begin
					b.tok[0] = '{stok_pkg::K_INT, start_q, len_q, 1'b0};
					b.cnt = 3'd1;
				end
				stok_pkg::M_INT_DOT: begin
					b.tok[0] = '{stok_pkg::K_INT, start_q, len_q, 1'b0};
					b.tok[1] = '{stok_pkg::K_DOT, pos_q - 1'b1, stok_pkg::LEN_BITS'(1), 1'b0};
					b.cnt = 3'd2;
				end
				stok_pkg::M_FLOAT: begin
					b.tok[0] = '{stok_pkg::K_FLOAT, start_q, len_q, 1'b0};
					b.cnt = 3'd1;
				end
				stok_pkg::M_STRING, stok_pkg::M_STR_ESC: begin
					b.tok[0] = '{stok_pkg::K_ERROR, start_q, len_q, 1'b0};
					b.cnt = 3'd1;
				end
				default: ;
			endcase
			b.tok[b.cnt[1:0]] = '{stok_pkg::K_END, pos_q, '0, 1'b0};
			b.cnt = b.cnt + 3'd1;
			mode_d = stok_pkg::M_IDLE;
			first_d = '0;
			kw_d = '0;
			start_d = '0;
			len_d = '0;
		end else begin
			unique case (mode_q)
				stok_pkg::M_OP1: begin
					k = stok_pkg::op2(first_q, ch);
					if (first_q == "/" && ch == "/") mode_d = stok_pkg::M_LINE;
					else if (first_q == "/" && ch == "*") mode_d = stok_pkg::M_BLOCK;
					else if ((first_q == "<" || first_q == ">") && ch == first_q)
						mode_d = stok_pkg::M_OP2;
					else if (k != stok_pkg::K_ERROR) begin
						b.tok[0] = '{k, start_q, stok_pkg::LEN_BITS'(2), 1'b0};
						b.cnt = 3'd1;
						mode_d = stok_pkg::M_IDLE;
					end else begin
						b.tok[0] = '{stok_pkg::op1(first_q), start_q,
							stok_pkg::LEN_BITS'(1), 1'b0};
						b.cnt = 3'd1;
						idle_scan = 1'b1;
					end
				end
				stok_pkg::M_OP2: begin
					if (ch == "=") begin
						b.tok[0] = '{(first_q == "<") ? stok_pkg::K_OP0 : stok_pkg::K_OP0 + 7'd1,
							start_q, stok_pkg::LEN_BITS'(3), 1'b0};
						b.cnt = 3'd1;
						mode_d = stok_pkg::M_IDLE;
					end else begin
						b.tok[0] = '{stok_pkg::op2(first_q, first_q), start_q,
							stok_pkg::LEN_BITS'(2), 1'b0};
						b.cnt = 3'd1;
						idle_scan = 1'b1;
					end
				end
				stok_pkg::M_IDENT: begin
					if (stok_pkg::is_alpha(ch) || stok_pkg::is_digit(ch)) begin
						for (int i = 0; i < stok_pkg::KEYWORD_CHARS; i++)
							if (len_q == stok_pkg::LEN_BITS'(i)) kw_d[8*i +: 8] = ch;
						len_d = grow(len_q);
					end else begin
						b.tok[0] = '{stok_pkg::kw_kind(kw_q, len_q), start_q, len_q, 1'b0};
						b.cnt = 3'd1;
						idle_scan = 1'b1;
					end
				end
				stok_pkg::M_INT: begin
					if (stok_pkg::is_digit(ch)) len_d = grow(len_q);
					else if (ch == ".") mode_d = stok_pkg::M_INT_DOT;
					else begin
						b.tok[0] = '{stok_pkg::K_INT, start_q, len_q, 1'b0};
						b.cnt = 3'd1;
						idle_scan = 1'b1;
					end
				end
				stok_pkg::M_INT_DOT: begin
					if (stok_pkg::is_digit(ch)) begin
						len_d = grow(grow(len_q));
						mode_d = stok_pkg::M_FLOAT;
					end else begin
						b.tok[0] = '{stok_pkg::K_INT, start_q, len_q, 1'b0};
						b.tok[1] = '{stok_pkg::K_DOT, pos_q - 1'b1, stok_pkg::LEN_BITS'(1), 1'b0};
						b.cnt = 3'd2;
						idle_scan = 1'b1;
					end
				end
				stok_pkg::M_FLOAT: begin
					if (stok_pkg::is_digit(ch)) len_d = grow(len_q);
					else begin
						b.tok[0] = '{stok_pkg::K_FLOAT, start_q, len_q, 1'b0};
						b.cnt = 3'd1;
						idle_scan = 1'b1;
					end
				end
				stok_pkg::M_STRING: begin
					len_d = grow(len_q);
					if (ch == "\\") mode_d = stok_pkg::M_STR_ESC;
					else if (ch == "\"") begin
						b.tok[0] = '{stok_pkg::K_STRING, start_q, len_d, 1'b0};
						b.cnt = 3'd1;
						mode_d = stok_pkg::M_IDLE;
					end
				end
				stok_pkg::M_STR_ESC: begin
					len_d = grow(len_q);
					mode_d = stok_pkg::M_STRING;
				end
				stok_pkg::M_LINE: if (ch == 8'd10) mode_d = stok_pkg::M_IDLE;
				stok_pkg::M_BLOCK: if (ch == "*") mode_d = stok_pkg::M_BLOCK_STAR;
				stok_pkg::M_BLOCK_STAR: begin
					if (ch == "/") mode_d = stok_pkg::M_IDLE;
					else if (ch != "*") mode_d = stok_pkg::M_BLOCK;
				end
				default: idle_scan = 1'b1;
			endcase
			// a fresh token starting at this byte
			if (idle_scan) begin
				mode_d = stok_pkg::M_IDLE;
				if (!stok_pkg::is_space(ch)) begin
					start_d = pos_q;
					len_d = stok_pkg::LEN_BITS'(1);
					if (ch == "\"") mode_d = stok_pkg::M_STRING;
					else if (stok_pkg::is_alpha(ch)) begin
						mode_d = stok_pkg::M_IDENT;
						kw_d = stok_pkg::KW_BITS'(ch);
					end else if (stok_pkg::is_digit(ch)) mode_d = stok_pkg::M_INT;
					else if (stok_pkg::starts_long(ch)) begin
						mode_d = stok_pkg::M_OP1;
						first_d = ch;
					end else begin
						b.tok[b.cnt[1:0]] = '{stok_pkg::op1(ch), pos_q,
							stok_pkg::LEN_BITS'(1), 1'b0};
						b.cnt = b.cnt + 3'd1;
					end
				end
			end
		end
		if (b.cnt != 3'd0) b.tok[b.cnt[1:0] - 2'd1].last = 1'b1;
	end

	assign bundle = b;
	assign push = fire && (b.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stok_pkg::M_IDLE;
			first_q <= '0;
			kw_q <= '0;
			start_q <= '0;
			len_q <= '0;
			pos_q <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			first_q <= first_d;
			kw_q <= kw_d;
			start_q <= start_d;
			len_q <= len_d;
			pos_q <= end_of_input ? '0 : pos_q + 1'b1;
		end
	end

	`ST_ASSERT(a_no_push_when_full, !(push && q_full), "front pushed into a full queue")
	`ST_ASSERT_NEXT(a_eoi_resets, fire && end_of_input,
		mode_q == stok_pkg::M_IDLE && pos_q == '0, "end of input did not reset state")
	`ST_ASSERT(a_push_count, !push || (bundle.cnt != 3'd0 && bundle.cnt <= 3'd4),
		"bad token count")
endmodule

### rtl/stok_queue.sv
`timescale 1ns / 1ps
`include "source_tokenizer_defines.svh"
module stok_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input stok_pkg::bundle_t wdata,
	output logic full,
	input logic pop,
	output logic empty,
	output stok_pkg::bundle_t rdata
);
	stok_pkg::bundle_t mem_q [stok_pkg::QDEPTH];
	logic [stok_pkg::QAW-1:0] wp_q, rp_q;
	logic [stok_pkg::QAW:0] cnt_q;

	assign full = cnt_q == (stok_pkg::QAW+1)'(stok_pkg::QDEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (stok_pkg::QAW+1)'(push) - (stok_pkg::QAW+1)'(pop);
		end
	end

	`ST_ASSERT(a_no_overflow, !(push && full), "queue overflow")
	`ST_ASSERT(a_no_underflow, !(pop && empty), "queue underflow")
	`ST_ASSERT(a_count_range, cnt_q <= (stok_pkg::QAW+1)'(stok_pkg::QDEPTH),
		"queue count out of range")
endmodule

### rtl/stok_back.sv
`timescale 1ns / 1ps
`include "source_tokenizer_defines.svh"
module stok_back (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input stok_pkg::bundle_t rdata,
	output logic pop,
	output logic out_valid,
	input logic out_ready,
	output stok_pkg::tok_t tok
);
	logic [1:0] idx_q;
	logic take;

	assign out_valid = !empty;
	assign tok = rdata.tok[idx_q];
	assign take = out_valid && out_ready;
	assign pop = take && (3'(idx_q) + 3'd1 == rdata.cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) idx_q <= '0;
		else if (take) idx_q <= pop ? 2'd0 : idx_q + 2'd1;
	end

	`ST_ASSERT(a_idx_in_bundle, empty || 3'(idx_q) < rdata.cnt, "token index past bundle")
	`ST_ASSERT(a_last_on_pop, !take || (pop == tok.last), "last mark out of step with pop")
	`ST_ASSERT_NEXT(a_hold_stall, out_valid && !out_ready, out_valid && $stable(tok),
		"token changed under stall")
endmodule
